// File: sv/dsp_pkg.sv
`timescale 1ns / 1ps

package dsp_pkg;

  // Width of each date field on the result bus.
  localparam int unsigned OutWidth = 20;

  // Character codes of the decimal digits.
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // A number above this is taken to be a year in free mode.
  localparam int unsigned YearFloor = 1000;

  // Field slots; SlotNone marks a finished or discarded field.
  localparam logic [1:0] SlotYear  = 2'd0;
  localparam logic [1:0] SlotMonth = 2'd1;
  localparam logic [1:0] SlotDay   = 2'd2;
  localparam logic [1:0] SlotNone  = 2'd3;

  // One parsed date as it leaves the block.
  typedef struct packed {
    logic                valid_res;
    logic [OutWidth-1:0] day;
    logic [OutWidth-1:0] month;
    logic [OutWidth-1:0] year;
  } date_res_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CharZero) && (ch <= CharNine);
  endfunction

endpackage

// File: sv/date_string_parser.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata=ch, tuser=has_char, tlast=last
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata={day,month,year}, tuser=valid_res
// cfg       in   cfg_we_i (no stall)              cfg_wdata_i = mode_w3c
//
// One input beat is taken every cycle unless the skid register is full. The parse
// state is updated in the cycle a beat is accepted, and the result of a string is
// written into the output buffer when its last beat is accepted. A two-entry output
// buffer (result register plus a skid register) lets the input keep flowing while a
// result waits; the input only stalls when both entries are full. Reset clears the
// parse state, the mode (free mode) and the output buffer.
module date_string_parser #(
  parameter int unsigned NUM_WIDTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // mode_w3c
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tuser_i,   // [0] has_char
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [19:0] year, [39:20] month, [59:40] day, rest 0
  output logic        m_axis_tuser_o    // [0] valid_res
);
  import dsp_pkg::*;

  localparam int unsigned NumFields = 3;
  localparam logic [NUM_WIDTH-1:0] YearFloorN = NUM_WIDTH'(YearFloor);

  // Mode register.
  logic mode_w3c_q;

  // Parse state for the string in flight.
  logic [1:0]           field_index_q, field_index_d;
  logic                 in_digits_q, in_digits_d;
  logic [1:0]           num_count_q, num_count_d;
  logic [NUM_WIDTH-1:0] store_q [NumFields];
  logic [NUM_WIDTH-1:0] store_d [NumFields];

  // Output buffer.
  logic      out_valid_q, skid_valid_q;
  date_res_t out_q, skid_q;

  logic                 accept;
  logic                 pop;
  logic                 push;
  logic                 digit;
  logic [1:0]           slot;
  logic [NUM_WIDTH-1:0] acc_in;
  logic [NUM_WIDTH-1:0] acc_out;
  logic [1:0]           field_index_u;
  logic                 in_digits_u;
  logic [1:0]           num_count_u;
  logic [NUM_WIDTH-1:0] store_u [NumFields];
  date_res_t            res;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = accept && s_axis_tlast_i;
  assign pop             = out_valid_q && m_axis_tready_i;

  assign digit = is_digit(s_axis_tdata_i);

  // Pick the slot this character lands in. In free mode a new digit run takes
  // the next free slot, or is thrown away once three runs have been seen.
  always_comb begin
    if (!mode_w3c_q && !in_digits_q) begin
      slot = (num_count_q == SlotNone) ? SlotNone : num_count_q;
    end else begin
      slot = field_index_q;
    end
  end

  assign acc_in = (slot == SlotNone) ? '0 : store_q[slot];

  dsp_acc #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_acc (
    .value_i(acc_in),
    .digit_i(s_axis_tdata_i[3:0]),
    .value_o(acc_out)
  );

  // State after the character of this beat, before the end of string clears it.
  always_comb begin
    field_index_u = field_index_q;
    in_digits_u   = in_digits_q;
    num_count_u   = num_count_q;
    for (int i = 0; i < NumFields; i++) begin
      store_u[i] = store_q[i];
    end
    if (s_axis_tuser_i) begin
      if (mode_w3c_q) begin
        if (field_index_q != SlotNone) begin
          if (digit) begin
            store_u[field_index_q] = acc_out;
          end else begin
            field_index_u = field_index_q + 2'd1;
          end
        end
      end else if (digit) begin
        if (!in_digits_q) begin
          field_index_u = slot;
          if (num_count_q != SlotNone) begin
            num_count_u = num_count_q + 2'd1;
          end
        end
        in_digits_u = 1'b1;
        if (slot != SlotNone) begin
          store_u[slot] = acc_out;
        end
      end else begin
        in_digits_u = 1'b0;
      end
    end
  end

  function automatic logic [OutWidth-1:0] to_out(input logic [NUM_WIDTH-1:0] v);
    logic [NUM_WIDTH+OutWidth-1:0] wide;
    wide = {{OutWidth{1'b0}}, v};
    return wide[OutWidth-1:0];
  endfunction

  // Field ordering at the end of the string.
  always_comb begin
    res = '0;
    if (mode_w3c_q) begin
      res.year      = to_out(store_u[SlotYear]);
      res.month     = to_out(store_u[SlotMonth]);
      res.day       = to_out(store_u[SlotDay]);
      res.valid_res = 1'b1;
    end else if (num_count_u == SlotNone) begin
      if (store_u[SlotYear] > YearFloorN) begin
        res.year      = to_out(store_u[SlotYear]);
        res.month     = to_out(store_u[SlotMonth]);
        res.day       = to_out(store_u[SlotDay]);
        res.valid_res = 1'b1;
      end else if (store_u[SlotDay] > YearFloorN) begin
        // Day-month-year order: the first run is the day.
        res.day       = to_out(store_u[SlotYear]);
        res.month     = to_out(store_u[SlotMonth]);
        res.year      = to_out(store_u[SlotDay]);
        res.valid_res = 1'b1;
      end
    end
  end

  // Next parse state: the end of a string starts the next one from scratch.
  always_comb begin
    field_index_d = field_index_q;
    in_digits_d   = in_digits_q;
    num_count_d   = num_count_q;
    for (int i = 0; i < NumFields; i++) begin
      store_d[i] = store_q[i];
    end
    if (accept) begin
      if (s_axis_tlast_i) begin
        field_index_d = '0;
        in_digits_d   = 1'b0;
        num_count_d   = '0;
        for (int i = 0; i < NumFields; i++) begin
          store_d[i] = '0;
        end
      end else begin
        field_index_d = field_index_u;
        in_digits_d   = in_digits_u;
        num_count_d   = num_count_u;
        for (int i = 0; i < NumFields; i++) begin
          store_d[i] = store_u[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_w3c_q    <= 1'b0;
      field_index_q <= '0;
      in_digits_q   <= 1'b0;
      num_count_q   <= '0;
      for (int i = 0; i < NumFields; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mode_w3c_q <= cfg_wdata_i;
      end
      field_index_q <= field_index_d;
      in_digits_q   <= in_digits_d;
      num_count_q   <= num_count_d;
      for (int i = 0; i < NumFields; i++) begin
        store_q[i] <= store_d[i];
      end
    end
  end

  // Output buffer: the result register refills from the skid register first,
  // so results leave in order. The skid only fills while the result register
  // is held by the sink.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.day, out_q.month, out_q.year};
  assign m_axis_tuser_o  = out_q.valid_res;

  // The skid register is only ever used behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  // The end of a string always leaves a clean parse state behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (field_index_q == '0) && (num_count_q == '0) && !in_digits_q)
    else $error("parse state not cleared after end of string");

  // A rejected date carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("invalid result with nonzero fields");

  // A result appears in the cycle after the last beat when the buffer was empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_valid_q) |=> out_valid_q)
    else $error("result lost after end of string");

endmodule

// File: sv/dsp_acc.sv
`timescale 1ns / 1ps

// Decimal accumulate step: value * 10 + digit, saturating at the all-ones value.
module dsp_acc #(
  parameter int unsigned NUM_WIDTH = 20
) (
  input  logic [NUM_WIDTH-1:0] value_i,
  input  logic [3:0]           digit_i,
  output logic [NUM_WIDTH-1:0] value_o
);

  localparam int unsigned WideWidth = NUM_WIDTH + 4;

  logic [WideWidth-1:0] times_ten;
  logic [WideWidth-1:0] sum;

  // Times ten as two shifted copies, no multiplier needed.
  assign times_ten = {1'b0, value_i, 3'b000} + {3'b000, value_i, 1'b0};
  assign sum       = times_ten + {{NUM_WIDTH{1'b0}}, digit_i};

  assign value_o = (sum[WideWidth-1:NUM_WIDTH] != 4'd0) ? {NUM_WIDTH{1'b1}}
                                                        : sum[NUM_WIDTH-1:0];

endmodule

// File: sim/date_string_parser_test.sv
`timescale 1ns / 1ps

module date_string_parser_test;
  import dsp_pkg::*;

  localparam int unsigned NumWidth = 20;
  localparam logic [63:0] NumMax   = (64'd1 << NumWidth) - 64'd1;

  localparam logic ModeFree = 1'b0;
  localparam logic ModeW3c  = 1'b1;

  // Run counter value once three digit runs have been seen in free mode.
  localparam logic [1:0] RunsFull = 2'd3;

  // How a string is closed off.
  localparam int EndOnChar = 0;
  localparam int EndBare   = 1;
  localparam int EndNone   = 2;

  localparam int DrainCycles = 4;
  localparam int CycleLimit  = 600000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tuser   = 1'b0;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  date_string_parser #(
    .NUM_WIDTH(NumWidth)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #6 clk = ~clk;

  // Parser state mirrored on the testbench side.
  logic                mode_q;
  logic [1:0]          slot_q;
  logic                in_run_q;
  logic [1:0]          runs_q;
  logic [NumWidth-1:0] acc_q [3];

  date_res_t   date_q [$];   // dates still owed by the block, oldest first
  logic [7:0]  text_q [$];   // characters of the string about to be sent
  int unsigned beats_sent   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int          src_pct      = 0;
  int          sink_pct     = 0;
  int          sink_hold    = 0;

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic reset_parse();
    slot_q   = SlotYear;
    in_run_q = 1'b0;
    runs_q   = 2'd0;
    acc_q[0] = '0;
    acc_q[1] = '0;
    acc_q[2] = '0;
  endtask

  // Decimal accumulate with saturation at the full number width.
  task automatic add_digit(input logic [1:0] slot, input logic [3:0] d);
    logic [63:0] v;
    if (slot == SlotNone) return;
    v = 64'(acc_q[slot]) * 64'd10 + 64'(d);
    if (v > NumMax) v = NumMax;
    acc_q[slot] = v[NumWidth-1:0];
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic       dig;
    logic [3:0] d;
    dig = (c >= CharZero) && (c <= CharNine);
    d   = dig ? 4'(c - CharZero) : 4'd0;
    if (mode_q == ModeW3c) begin
      // Fixed fields: a digit extends the current one, anything else moves on.
      if (slot_q != SlotNone) begin
        if (dig) add_digit(slot_q, d);
        else slot_q = slot_q + 2'd1;
      end
    end else if (dig) begin
      // Free mode: a new run takes the next slot, runs past the third are dropped.
      if (!in_run_q) begin
        if (runs_q != RunsFull) begin
          slot_q = runs_q;
          runs_q = runs_q + 2'd1;
        end else begin
          slot_q = SlotNone;
        end
        in_run_q = 1'b1;
      end
      add_digit(slot_q, d);
    end else begin
      in_run_q = 1'b0;
    end
  endtask

  task automatic close_date(output date_res_t r);
    r = '0;
    if (mode_q == ModeW3c) begin
      r.year      = acc_q[SlotYear][OutWidth-1:0];
      r.month     = acc_q[SlotMonth][OutWidth-1:0];
      r.day       = acc_q[SlotDay][OutWidth-1:0];
      r.valid_res = 1'b1;
    end else if (runs_q == RunsFull) begin
      if (acc_q[0] > YearFloor) begin
        r.year      = acc_q[0][OutWidth-1:0];
        r.month     = acc_q[1][OutWidth-1:0];
        r.day       = acc_q[2][OutWidth-1:0];
        r.valid_res = 1'b1;
      end else if (acc_q[2] > YearFloor) begin
        r.day       = acc_q[0][OutWidth-1:0];
        r.month     = acc_q[1][OutWidth-1:0];
        r.year      = acc_q[2][OutWidth-1:0];
        r.valid_res = 1'b1;
      end
    end
    reset_parse();
  endtask

  // Offers one beat and returns at the clock edge that takes it.
  task automatic send_beat(input logic [7:0] ch, input logic has_ch, input logic last);
    int        gap;
    logic      took;
    date_res_t r;
    if (src_pct != 0 && $urandom_range(99) < src_pct) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= has_ch;
    s_tlast  <= last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_axis_tready_o;
      @(posedge clk);
    end
    if (has_ch) parse_char(ch);
    if (last) begin
      close_date(r);
      date_q = {date_q, r};
    end
    if (has_ch || last) beats_sent++;
  endtask

  // Sends text_q; now and then a bare beat without last is slipped in.
  task automatic send_text(input int end_kind);
    int i;
    int n;
    n = text_q.size();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(text_q[i], 1'b1, (end_kind == EndOnChar) && (i == n - 1));
    end
    if (end_kind == EndBare || (end_kind == EndOnChar && n == 0))
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q = {text_q, s[i]};
  endtask

  task automatic send_str(input string s, input int end_kind);
    text_q.delete();
    push_str(s);
    send_text(end_kind);
  endtask

  // Waits until every owed date has come out and the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (date_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    mode_q = m;
    cfg_we <= 1'b0;
  endtask

  task automatic push_run(input logic year_like);
    int unsigned v;
    int          r;
    r = $urandom_range(15);
    if (year_like)
      v = (r == 0) ? $urandom_range(999, 1002) :
          (r == 1) ? $urandom_range(99999999) : $urandom_range(1900, 2100);
    else
      v = (r == 0) ? $urandom_range(99999999) : $urandom_range(31);
    if ($urandom_range(3) == 0) push_str($sformatf("%02d", v));
    else push_str($sformatf("%0d", v));
  endtask

  task automatic push_sep();
    string seps;
    seps = "-/. :T,";
    if ($urandom_range(15) == 0) text_q = {text_q, 8'($urandom_range(255))};
    else text_q = {text_q, seps[$urandom_range(seps.len() - 1)]};
  endtask

  // One random string: mostly dates in either order, some with a time tail,
  // some with empty fields, and a share of broken strings and raw noise.
  task automatic make_text();
    int kind;
    int k;
    text_q.delete();
    kind = $urandom_range(19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 12)) text_q = {text_q, 8'($urandom_range(255))};
    end else if (kind < 4) begin
      k = $urandom_range(2);
      repeat (k) begin
        push_run($urandom_range(1));
        push_sep();
      end
    end else if (kind < 10) begin
      push_run(1'b1); push_sep(); push_run(1'b0); push_sep(); push_run(1'b0);
    end else if (kind < 14) begin
      push_run(1'b0); push_sep(); push_run(1'b0); push_sep(); push_run(1'b1);
    end else if (kind < 17) begin
      push_run(1'b1); push_str("-"); push_run(1'b0); push_str("-"); push_run(1'b0);
      push_str("T"); push_run(1'b0); push_str(":"); push_run(1'b0);
      if ($urandom_range(1)) push_str("Z");
    end else begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(2) != 0) push_run($urandom_range(1));
        push_sep();
      end
    end
  endtask

  task automatic test_free_directed();
    write_mode(ModeFree);
    send_str("9/8/1001", EndOnChar);  // third run is the year
    send_str("1/2/3", EndBare);       // no run above the year floor
    send_str("", EndBare);            // bare end marker alone
  endtask

  task automatic test_w3c_directed();
    write_mode(ModeW3c);
    send_str("12345678", EndOnChar);  // year saturates, month and day empty
  endtask

  task automatic test_mode_change();
    write_mode(ModeFree);
    send_str("1001 2", EndNone);
    write_mode(ModeW3c);
    send_str("-3", EndBare);
    send_str("5-", EndNone);
    write_mode(ModeFree);
    send_str("6 7 2000", EndOnChar);
  endtask

  task automatic test_random_strings(input logic m, input int src, input int sink,
                                     input int unsigned n);
    int unsigned target;
    int          e;
    write_mode(m);
    src_pct  = src;
    sink_pct = sink;
    target   = beats_sent + n;
    while (beats_sent < target) begin
      make_text();
      e = ($urandom_range(6) == 0) ? EndBare : EndOnChar;
      send_text(e);
    end
  endtask

  // Result side: random back-pressure in the same style as the input gaps.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      m_tready <= 1'b0;
    end else if (sink_pct != 0 && $urandom_range(99) < sink_pct) begin
      sink_hold = pick_gap() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Handshake inputs are steady between the falling and the rising edge, so a
  // result seen here with ready high is the one taken at the next rising edge.
  always @(negedge clk) begin
    date_res_t got;
    date_res_t want;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      got.year      = m_axis_tdata_o[OutWidth-1:0];
      got.month     = m_axis_tdata_o[2*OutWidth-1:OutWidth];
      got.day       = m_axis_tdata_o[3*OutWidth-1:2*OutWidth];
      got.valid_res = m_axis_tuser_o;
      if (date_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected date: y=%0d m=%0d d=%0d ok=%0b",
                   got.year, got.month, got.day, got.valid_res);
      end else begin
        want = date_q.pop_front();
        if (got.year !== want.year || got.month !== want.month ||
            got.day !== want.day || got.valid_res !== want.valid_res) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("date mismatch: expected y=%0d m=%0d d=%0d ok=%0b, got y=%0d m=%0d d=%0d ok=%0b",
                     want.year, want.month, want.day, want.valid_res,
                     got.year, got.month, got.day, got.valid_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mode_q = ModeFree;
    reset_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    sink_pct = 30;
    test_free_directed();
    test_w3c_directed();
    test_mode_change();
    test_random_strings(ModeFree, 25, 25, 250);
    test_random_strings(ModeW3c, 25, 25, 250);
    test_random_strings(ModeFree, 0, 0, 250);
    test_random_strings(ModeW3c, 10, 70, 250);
    test_random_strings(ModeFree, 60, 10, 250);
    settle();
    if (mismatch_cnt == 0 && date_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dsp_pkg.sv
sv/dsp_acc.sv
sv/date_string_parser.sv
sim/date_string_parser_test.sv
